/* hw/rtl/assert_macros.svh */
// assertion macros used by the laplacian stencil controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property checked on every rising clock edge out of reset
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen on a rising clock edge out of reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_SYNC(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

/* hw/rtl/l3s_pkg.sv */
// shared types and constants of the seven-point laplacian stencil
package l3s_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X_SQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y_SQ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z_SQ   = 3'd5;
    localparam int CFG_DATA_W = 32;

    localparam int SIZE_REG_W = 6;
    // holds any grid dimension in use; the size registers reach at most 63
    localparam int SIZE_W     = 9;
    localparam int COORD_W    = 5;
    localparam int SAMPLE_W   = 32;
    localparam int INV_W      = 32;
    localparam int DIFF_W     = 35;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = DIFF_W + MUL_B_W;
    localparam int ACC_W      = 54;
    localparam int LAP_W      = 64;

    // action codes
    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // status codes
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_RANGE = 1'b1;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_CENTRE,
        RK_PLUS,
        RK_MINUS
    } rd_kind_t;

    typedef struct packed {
        logic     start;
        logic     write;
        logic     rd_en;
        rd_kind_t rd_kind;
        axis_t    axis;
        logic     load_out;
    } l3s_cmd_t;

    typedef struct packed {
        logic       err;
        logic       compute;
        logic [2:0] axis_en;
        logic       busy;
    } l3s_stat_t;

endpackage

/* hw/rtl/l3s_ram.sv */
// generic single-port ram with registered read
module l3s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/l3s_ctrl.sv */
// controller state machine: sequences store writes, stencil reads and result hand-off
`include "assert_macros.svh"

module l3s_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  l3s_pkg::l3s_stat_t stat,
    output l3s_pkg::l3s_cmd_t  cmd
);

    import l3s_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_C,
        ST_RD_P,
        ST_RD_M,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;
    logic   m_tvalid_reg, m_tvalid_next;

    axis_t first_axis;
    axis_t after_axis;
    logic  has_after;
    logic  slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (stat.axis_en[AXIS_X]) begin
            first_axis = AXIS_X;
        end else if (stat.axis_en[AXIS_Y]) begin
            first_axis = AXIS_Y;
        end else begin
            first_axis = AXIS_Z;
        end
    end

    always_comb begin
        has_after  = 1'b0;
        after_axis = axis_reg;
        case (axis_reg)
            AXIS_X: begin
                if (stat.axis_en[AXIS_Y]) begin
                    has_after  = 1'b1;
                    after_axis = AXIS_Y;
                end else if (stat.axis_en[AXIS_Z]) begin
                    has_after  = 1'b1;
                    after_axis = AXIS_Z;
                end
            end
            AXIS_Y: begin
                if (stat.axis_en[AXIS_Z]) begin
                    has_after  = 1'b1;
                    after_axis = AXIS_Z;
                end
            end
            default: begin
                has_after = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.rd_kind   = RK_NONE;
        cmd.axis      = axis_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.err || !stat.compute) begin
                    cmd.write  = !stat.err;
                    state_next = ST_FINISH;
                end else if (stat.axis_en == 3'b000) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next  = first_axis;
                    state_next = ST_RD_C;
                end
            end
            ST_RD_C: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = RK_CENTRE;
                state_next  = ST_RD_P;
            end
            ST_RD_P: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = RK_PLUS;
                state_next  = ST_RD_M;
            end
            ST_RD_M: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_kind = RK_MINUS;
                if (has_after) begin
                    axis_next  = after_axis;
                    state_next = ST_RD_P;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_reg     <= AXIS_X;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // a new result never overwrites one that is still waiting
    `ASSERT_SYNC(a_load_slot_free, aclk, aresetn, cmd.load_out |-> slot_free, "result overwritten")
    // single port: a write and a read never share a cycle
    `ASSERT_NEVER(a_no_wr_rd, aclk, aresetn, cmd.write && cmd.rd_en, "store write during read")
    // one word at a time
    `ASSERT_SYNC(a_one_word, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "accept while busy")
    // the result is loaded only once the multiply pipeline has drained
    `ASSERT_NEVER(a_finish_idle, aclk, aresetn, cmd.load_out && stat.busy, "result before drain")

endmodule

/* hw/rtl/l3s_dp.sv */
// datapath: config registers, item latch, address generation, difference and scaling
module l3s_dp #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [l3s_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [l3s_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
    input  logic                                   in_action,
    input  logic [l3s_pkg::COORD_W-1:0]            in_pos_x,
    input  logic [l3s_pkg::COORD_W-1:0]            in_pos_y,
    input  logic [l3s_pkg::COORD_W-1:0]            in_pos_z,
    input  logic [l3s_pkg::SAMPLE_W-1:0]           in_sample,
    input  l3s_pkg::l3s_cmd_t                      cmd,
    output l3s_pkg::l3s_stat_t                     stat,
    output logic                                   ram_en,
    output logic                                   ram_we,
    output logic [$clog2(MAX_X*MAX_Y*MAX_Z)-1:0]   ram_addr,
    output logic [l3s_pkg::SAMPLE_W-1:0]           ram_wdata,
    input  logic [l3s_pkg::SAMPLE_W-1:0]           ram_rdata,
    output logic [l3s_pkg::LAP_W-1:0]              lap_value,
    output logic                                   status
);

    import l3s_pkg::*;

    localparam int AW    = $clog2(MAX_X*MAX_Y*MAX_Z);
    localparam int PLANE = MAX_X * MAX_Y;

    logic [SIZE_REG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [INV_W-1:0]      inv_x_reg, inv_y_reg, inv_z_reg;

    logic                  action_reg;
    logic [COORD_W-1:0]    x_reg, y_reg, z_reg;
    logic [SAMPLE_W-1:0]   sample_reg;

    rd_kind_t              rd_kind_reg;
    axis_t                 rd_axis_reg;
    logic signed [SAMPLE_W-1:0] c_reg, nb_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    axis_t                 d_axis_reg;
    logic                  ph1_reg, ph2_reg, ph3_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [LAP_W-1:0]      lap_reg;
    logic                  status_reg;

    logic [SIZE_W-1:0]     n_x, n_y, n_z;
    logic [COORD_W-1:0]    xp, xm, yp, ym, zp, zm;
    logic [COORD_W-1:0]    ax, ay, az;
    logic                  err;
    logic [INV_W-1:0]      inv_sel;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [DIFF_W-1:0]   d_new;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_REG_W'(32);
            size_y_reg <= SIZE_REG_W'(32);
            size_z_reg <= SIZE_REG_W'(32);
            inv_x_reg  <= INV_W'(65536);
            inv_y_reg  <= INV_W'(65536);
            inv_z_reg  <= INV_W'(65536);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SIZE_X:   size_x_reg <= cfg_wr_data[SIZE_REG_W-1:0];
                CFG_SIZE_Y:   size_y_reg <= cfg_wr_data[SIZE_REG_W-1:0];
                CFG_SIZE_Z:   size_z_reg <= cfg_wr_data[SIZE_REG_W-1:0];
                CFG_INV_X_SQ: inv_x_reg  <= cfg_wr_data[INV_W-1:0];
                CFG_INV_Y_SQ: inv_y_reg  <= cfg_wr_data[INV_W-1:0];
                CFG_INV_Z_SQ: inv_z_reg  <= cfg_wr_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sizes in use are limited to the store dimensions
    assign n_x = (SIZE_W'(size_x_reg) > SIZE_W'(MAX_X)) ? SIZE_W'(MAX_X) : SIZE_W'(size_x_reg);
    assign n_y = (SIZE_W'(size_y_reg) > SIZE_W'(MAX_Y)) ? SIZE_W'(MAX_Y) : SIZE_W'(size_y_reg);
    assign n_z = (SIZE_W'(size_z_reg) > SIZE_W'(MAX_Z)) ? SIZE_W'(MAX_Z) : SIZE_W'(size_z_reg);

    assign err = (SIZE_W'(x_reg) >= n_x) || (SIZE_W'(y_reg) >= n_y) || (SIZE_W'(z_reg) >= n_z);

    assign stat.err        = err;
    assign stat.compute    = (action_reg == ACT_COMPUTE);
    assign stat.axis_en[0] = (n_x > SIZE_W'(1));
    assign stat.axis_en[1] = (n_y > SIZE_W'(1));
    assign stat.axis_en[2] = (n_z > SIZE_W'(1));
    assign stat.busy       = (rd_kind_reg != RK_NONE) || ph1_reg || ph2_reg || ph3_reg;

    // clamped neighbours
    assign xp = (SIZE_W'(x_reg) + SIZE_W'(1) >= n_x) ? x_reg : x_reg + COORD_W'(1);
    assign yp = (SIZE_W'(y_reg) + SIZE_W'(1) >= n_y) ? y_reg : y_reg + COORD_W'(1);
    assign zp = (SIZE_W'(z_reg) + SIZE_W'(1) >= n_z) ? z_reg : z_reg + COORD_W'(1);
    assign xm = (x_reg == '0) ? x_reg : x_reg - COORD_W'(1);
    assign ym = (y_reg == '0) ? y_reg : y_reg - COORD_W'(1);
    assign zm = (z_reg == '0) ? z_reg : z_reg - COORD_W'(1);

    always_comb begin
        ax = x_reg;
        ay = y_reg;
        az = z_reg;
        if (cmd.rd_kind == RK_PLUS || cmd.rd_kind == RK_MINUS) begin
            case (cmd.axis)
                AXIS_X:  ax = (cmd.rd_kind == RK_PLUS) ? xp : xm;
                AXIS_Y:  ay = (cmd.rd_kind == RK_PLUS) ? yp : ym;
                AXIS_Z:  az = (cmd.rd_kind == RK_PLUS) ? zp : zm;
                default: ax = x_reg;
            endcase
        end
    end

    // raster order, x fastest
    assign ram_addr  = AW'(32'(az) * PLANE + 32'(ay) * MAX_X + 32'(ax));
    assign ram_en    = cmd.write || cmd.rd_en;
    assign ram_we    = cmd.write;
    assign ram_wdata = sample_reg;

    assign d_new = DIFF_W'(nb_reg) + DIFF_W'($signed(ram_rdata)) - (DIFF_W'(c_reg) <<< 1);

    always_comb begin
        case (d_axis_reg)
            AXIS_X:  inv_sel = inv_x_reg;
            AXIS_Y:  inv_sel = inv_y_reg;
            AXIS_Z:  inv_sel = inv_z_reg;
            default: inv_sel = inv_x_reg;
        endcase
    end

    // low half of the reciprocal first, then the high half
    assign mul_b = ph1_reg ? $signed({1'b0, inv_sel[15:0]}) : $signed({1'b0, inv_sel[31:16]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_kind_reg <= RK_NONE;
            ph1_reg     <= 1'b0;
            ph2_reg     <= 1'b0;
            ph3_reg     <= 1'b0;
        end else begin
            rd_kind_reg <= cmd.rd_en ? cmd.rd_kind : RK_NONE;
            ph1_reg     <= (rd_kind_reg == RK_MINUS);
            ph2_reg     <= ph1_reg;
            ph3_reg     <= ph2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            action_reg <= in_action;
            x_reg      <= in_pos_x;
            y_reg      <= in_pos_y;
            z_reg      <= in_pos_z;
            sample_reg <= in_sample;
        end
        rd_axis_reg <= cmd.axis;
        case (rd_kind_reg)
            RK_CENTRE: c_reg  <= $signed(ram_rdata);
            RK_PLUS:   nb_reg <= $signed(ram_rdata);
            RK_MINUS: begin
                d_reg      <= d_new;
                d_axis_reg <= rd_axis_reg;
            end
            default: begin
            end
        endcase
        if (ph1_reg || ph2_reg) begin
            prod_reg <= d_reg * mul_b;
        end
        // floor of the low partial product, then the high partial product whole
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (ph2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> 16);
        end else if (ph3_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.load_out) begin
            lap_reg    <= LAP_W'(acc_reg);
            status_reg <= err ? STAT_RANGE : STAT_OK;
        end
    end

    assign lap_value = lap_reg;
    assign status    = status_reg;

endmodule

/* hw/rtl/laplacian_3d_stencil.sv */
// Seven-point Laplacian over a 3D grid of signed Q16.16 samples held in a single-port
// store of MAX_X*MAX_Y*MAX_Z words, raster order with x fastest. One word is taken at a
// time; the input is ready only while the block is idle. A store word, a word whose
// coordinate lies outside the grid in use, or a compute word with no axis above one has
// its result offered after the decode step, with no stencil reads. Any other compute
// word reads the store along each axis whose size in use exceeds one: the store port
// delivers one sample per cycle (centre, then the two neighbours of each axis), and one
// 35x17 multiplier scales each axis difference in two passes over the low and high
// halves of the reciprocal; the result is offered once those passes have drained. The
// next word is accepted while a result waits; its own result is held back until the
// waiting one is taken. The store has no reset; read only cells already written.
module laplacian_3d_stencil #(
    parameter int MAX_X = 32,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [l3s_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [l3s_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, sample_in, zero pad
    input  logic [47:0]                     s_tdata,
    // action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // lap_value
    output logic [63:0]                     m_tdata,
    // status
    output logic                            m_tuser
);

    import l3s_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);

    l3s_cmd_t             cmd;
    l3s_stat_t            stat;
    logic                 ram_en;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [SAMPLE_W-1:0]  ram_wdata;
    logic [SAMPLE_W-1:0]  ram_rdata;

    l3s_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    l3s_dp #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_tuser),
        .in_pos_x    (s_tdata[4:0]),
        .in_pos_y    (s_tdata[9:5]),
        .in_pos_z    (s_tdata[14:10]),
        .in_sample   (s_tdata[46:15]),
        .cmd         (cmd),
        .stat        (stat),
        .ram_en      (ram_en),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata),
        .lap_value   (m_tdata),
        .status      (m_tuser)
    );

    l3s_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
